[hdl/lps_pkg.sv]
// lps_pkg: shared types and constants of the led pattern sequencer
`default_nettype none

package lps_pkg;

   localparam int OPCODE_W = 2;
   localparam int POT_W    = 10;
   localparam int BASE_W   = 12;
   localparam int LED_W    = 8;
   localparam int SCALE_W  = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK = 2'd0,
      OP_PREV = 2'd1,
      OP_NEXT = 2'd2
   } opcode_type;

   localparam logic [BASE_W-1:0] BASE_DELAY_RESET = 12'd150;

   localparam logic [POT_W-1:0] TIER_1 = 10'd205;
   localparam logic [POT_W-1:0] TIER_2 = 10'd410;
   localparam logic [POT_W-1:0] TIER_3 = 10'd615;
   localparam logic [POT_W-1:0] TIER_4 = 10'd820;

   localparam logic [LED_W-1:0] SNAKE_START      = 8'b0000_0111;
   localparam logic [LED_W-1:0] SNAKE_LEFT_LIMIT = 8'b0111_1000;
   localparam logic [LED_W-1:0] SNAKE_RIGHT_END  = 8'b1110_0000;
   localparam logic [LED_W-1:0] SNAKE_TURN_LEFT  = 8'(SNAKE_START << 1);
   localparam logic [LED_W-1:0] COUNT_START      = 8'd255;

   typedef struct packed {
      logic [LED_W-1:0] led_pattern;
      logic             active_mode;
      logic             stepped;
   } result_type;

endpackage

`default_nettype wire

[hdl/lps_req_if.sv]
// lps_req_if: request channel carrying opcode and potentiometer sample
`default_nettype none

interface lps_req_if;
   logic                         valid;
   logic                         ready;
   logic [lps_pkg::OPCODE_W-1:0] opcode;
   logic [lps_pkg::POT_W-1:0]    pot_sample;

   modport source (output valid, output opcode, output pot_sample, input ready);
   modport sink   (input valid, input opcode, input pot_sample, output ready);
endinterface

`default_nettype wire

[hdl/lps_rsp_if.sv]
// lps_rsp_if: response channel carrying the led byte and status
`default_nettype none

interface lps_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lps_pkg::LED_W-1:0] led_pattern;
   logic                      active_mode;
   logic                      stepped;

   modport source (output valid, output led_pattern, output active_mode, output stepped,
                   input ready);
   modport sink   (input valid, input led_pattern, input active_mode, input stepped,
                   output ready);
endinterface

`default_nettype wire

[hdl/lps_period.sv]
// lps_period: speed tier scaling of the base delay into a step period
`default_nettype none

module lps_period #(
   parameter int PERIOD_BITS = 16
) (
   input  wire logic [lps_pkg::BASE_W-1:0] base_delay,
   input  wire logic [lps_pkg::POT_W-1:0]  pot_sample,
   output logic      [PERIOD_BITS-1:0]     period
);

   localparam int WIDE_W = (PERIOD_BITS > lps_pkg::SCALE_W) ? PERIOD_BITS : lps_pkg::SCALE_W;
   localparam logic [WIDE_W-1:0] PERIOD_MAX = WIDE_W'((65'd1 << PERIOD_BITS) - 65'd1);

   logic [lps_pkg::SCALE_W-1:0] base_ext;
   logic [lps_pkg::SCALE_W-1:0] scaled;
   logic [WIDE_W-1:0]           scaled_wide;
   logic [WIDE_W-1:0]           capped;

   assign base_ext = lps_pkg::SCALE_W'(base_delay);

   always_comb begin
      if (pot_sample < lps_pkg::TIER_1) begin
         scaled = base_ext >> 1;
      end else if (pot_sample < lps_pkg::TIER_2) begin
         scaled = base_ext << 2;
      end else if (pot_sample < lps_pkg::TIER_3) begin
         scaled = base_ext >> 2;
      end else if (pot_sample < lps_pkg::TIER_4) begin
         // times twelve as eight plus four
         scaled = (base_ext << 3) + (base_ext << 2);
      end else begin
         scaled = base_ext >> 3;
      end
   end

   assign scaled_wide = WIDE_W'(scaled);
   assign capped      = (scaled_wide > PERIOD_MAX) ? PERIOD_MAX : scaled_wide;
   assign period      = (capped == '0) ? PERIOD_BITS'(1) : capped[PERIOD_BITS-1:0];

endmodule

`default_nettype wire

[hdl/lps_engine.sv]
// lps_engine: pattern state, tick counter and per-beat step logic
`default_nettype none

module lps_engine #(
   parameter int PERIOD_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             step_en,
   input  wire logic [lps_pkg::OPCODE_W-1:0]     opcode,
   input  wire logic [lps_pkg::POT_W-1:0]        pot_sample,
   input  wire logic [lps_pkg::BASE_W-1:0]       base_delay,
   output lps_pkg::result_type                   result
);

   logic                      mode_ff, mode_in;
   logic [lps_pkg::LED_W-1:0] snake_ff, snake_in;
   logic                      left_ff, left_in;
   logic [lps_pkg::LED_W-1:0] down_ff, down_in;
   logic [PERIOD_BITS-1:0]    tick_ff, tick_in;
   logic [PERIOD_BITS-1:0]    period_ff, period_in;

   logic [PERIOD_BITS-1:0]    scaled_period;
   logic [PERIOD_BITS-1:0]    tick_inc;
   logic [lps_pkg::LED_W-1:0] shifted;
   logic                      stepped;

   lps_period #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_period (
      .base_delay (base_delay),
      .pot_sample (pot_sample),
      .period     (scaled_period)
   );

   assign tick_inc = tick_ff + PERIOD_BITS'(1);

   always_comb begin
      mode_in   = mode_ff;
      snake_in  = snake_ff;
      left_in   = left_ff;
      down_in   = down_ff;
      tick_in   = tick_ff;
      period_in = period_ff;
      shifted   = '0;
      stepped   = 1'b0;
      case (lps_pkg::opcode_type'(opcode))
         lps_pkg::OP_TICK: begin
            if (tick_ff == '0) begin
               period_in = scaled_period;
            end
            if (tick_inc >= period_in) begin
               tick_in = '0;
               stepped = 1'b1;
               if (!mode_ff) begin
                  if (left_ff) begin
                     shifted = snake_ff << 1;
                     if (shifted > lps_pkg::SNAKE_LEFT_LIMIT) begin
                        snake_in = lps_pkg::SNAKE_RIGHT_END;
                        left_in  = 1'b0;
                     end else begin
                        snake_in = shifted;
                     end
                  end else begin
                     shifted = snake_ff >> 1;
                     if (shifted < lps_pkg::SNAKE_START) begin
                        snake_in = lps_pkg::SNAKE_TURN_LEFT;
                        left_in  = 1'b1;
                     end else begin
                        snake_in = shifted;
                     end
                  end
               end else begin
                  down_in = down_ff - lps_pkg::LED_W'(1);
               end
            end else begin
               tick_in = tick_inc;
            end
         end
         lps_pkg::OP_PREV, lps_pkg::OP_NEXT: begin
            mode_in  = !mode_ff;
            snake_in = lps_pkg::SNAKE_START;
            left_in  = 1'b1;
            down_in  = lps_pkg::COUNT_START;
            tick_in  = '0;
            stepped  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         snake_ff  <= lps_pkg::SNAKE_START;
         left_ff   <= 1'b1;
         down_ff   <= lps_pkg::COUNT_START;
         tick_ff   <= '0;
         period_ff <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         snake_ff  <= snake_in;
         left_ff   <= left_in;
         down_ff   <= down_in;
         tick_ff   <= tick_in;
         period_ff <= period_in;
      end
   end

   assign result.led_pattern = mode_in ? down_in : snake_in;
   assign result.active_mode = mode_in;
   assign result.stepped     = stepped;

endmodule

`default_nettype wire

[hdl/led_pattern_sequencer.sv]
// led_pattern_sequencer: top level with request and response registers
//
// Usage: drive request beats on req_chan (opcode, pot_sample); opcode tick
// advances time, previous or next press toggles the mode and restarts the
// pattern. Every request beat yields exactly one response beat on rsp_chan
// carrying the led byte, the active mode and a stepped flag.
// csr_write_enable with csr_write_data loads base_delay (reset value 150);
// write it only while no beat is in flight.
// Path: an accepted request waits in the request register; the state update
// loads the response register from it when the response side has room.
// Throughput: one beat per cycle while rsp_chan.ready stays high, set by
// the single step of the state update between the two registers.
// Reset: synchronous, active high; both registers empty, snake mode at 0x07
// moving left, counter at 255, tick counter and period cleared.
// Stall: while rsp_chan.ready is low the response holds; one more request is
// still taken into the request register, then req_chan.ready drops.
`default_nettype none

module led_pattern_sequencer #(
   parameter int PERIOD_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lps_req_if.sink                            req_chan,
   lps_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [lps_pkg::BASE_W-1:0]    csr_write_data
);

   logic                         in_valid_ff, in_valid_in;
   logic [lps_pkg::OPCODE_W-1:0] in_opcode_ff;
   logic [lps_pkg::POT_W-1:0]    in_pot_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   lps_pkg::result_type          rsp_ff;
   logic [lps_pkg::BASE_W-1:0]   base_delay_ff;

   logic                         req_beat;
   logic                         rsp_load;
   lps_pkg::result_type          step_result;

   assign rsp_load       = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || rsp_load;
   assign req_beat       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_beat ? 1'b1 : (rsp_load ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   lps_engine #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_en    (rsp_load),
      .opcode     (in_opcode_ff),
      .pot_sample (in_pot_ff),
      .base_delay (base_delay_ff),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         base_delay_ff <= lps_pkg::BASE_DELAY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            base_delay_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_opcode_ff <= req_chan.opcode;
         in_pot_ff    <= req_chan.pot_sample;
      end
      if (rsp_load) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.led_pattern = rsp_ff.led_pattern;
   assign rsp_chan.active_mode = rsp_ff.active_mode;
   assign rsp_chan.stepped     = rsp_ff.stepped;

   // a press always reports a step
   press_reports_step: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (in_opcode_ff == lps_pkg::OP_PREV || in_opcode_ff == lps_pkg::OP_NEXT)
      |=> rsp_chan.valid && rsp_chan.stepped)
      else $error("press beat without stepped flag");

   // snake mode always shows three adjacent leds
   snake_three_leds: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.active_mode |-> $countones(rsp_chan.led_pattern) == 3)
      else $error("snake pattern lost its three leds");

   // request side only stalls when the request register is occupied
   stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && rsp_valid_ff && !rsp_chan.ready)
      else $error("request stalled with room available");

   // a held response that was not taken stays valid
   rsp_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff)
      else $error("response dropped without a beat");

endmodule

`default_nettype wire

[test/tb_led_pattern_sequencer.sv]
// tb_led_pattern_sequencer: random and directed check of the led pattern sequencer
`default_nettype none

module tb_led_pattern_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD_BITS = 16;
   localparam int IDLE_LIMIT  = 4000;
   localparam int REPORT_MAX  = 10;
   localparam int NUM_PHASES  = 7;
   localparam logic [lps_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

   typedef struct packed {
      logic [lps_pkg::OPCODE_W-1:0] opcode;
      logic [lps_pkg::POT_W-1:0]    pot_sample;
   } led_cmd_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [lps_pkg::BASE_W-1:0] csr_write_data = '0;

   lps_req_if req_chan ();
   lps_rsp_if rsp_chan ();

   led_pattern_sequencer uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // pattern state mirrored from the block
   logic [lps_pkg::BASE_W-1:0] base_delay_q  = lps_pkg::BASE_DELAY_RESET;
   logic                       mode_q        = 1'b0;
   logic [lps_pkg::LED_W-1:0]  snake_q       = lps_pkg::SNAKE_START;
   logic                       moving_left_q = 1'b1;
   logic [lps_pkg::LED_W-1:0]  down_q        = lps_pkg::COUNT_START;
   logic [PERIOD_BITS-1:0]     tick_q        = '0;
   logic [PERIOD_BITS-1:0]     period_q      = '0;

   led_cmd_type          pending_cmds[$];
   lps_pkg::result_type  expected_leds[$];

   int issued_count   = 0;
   int accepted_count = 0;
   int error_count    = 0;
   int idle_cycles    = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [PERIOD_BITS-1:0] scaled_period(
      input logic [lps_pkg::POT_W-1:0] pot);
      logic [31:0] n;
      if (pot < lps_pkg::TIER_1)      n = 32'(base_delay_q) / 2;
      else if (pot < lps_pkg::TIER_2) n = 32'(base_delay_q) * 4;
      else if (pot < lps_pkg::TIER_3) n = 32'(base_delay_q) / 4;
      else if (pot < lps_pkg::TIER_4) n = 32'(base_delay_q) * 12;
      else                            n = 32'(base_delay_q) / 8;
      if (n > 32'(PERIOD_MAX)) n = 32'(PERIOD_MAX);
      if (n == 0) n = 1;
      return n[PERIOD_BITS-1:0];
   endfunction

   function automatic lps_pkg::result_type step_led_state(input led_cmd_type cmd);
      lps_pkg::result_type res;
      logic                stepped;
      stepped = 1'b0;
      case (cmd.opcode)
         lps_pkg::OP_TICK: begin
            if (tick_q == 0) period_q = scaled_period(cmd.pot_sample);
            tick_q = tick_q + PERIOD_BITS'(1);
            if (tick_q >= period_q) begin
               if (!mode_q) begin
                  if (moving_left_q) begin
                     snake_q = snake_q << 1;
                     if (snake_q > lps_pkg::SNAKE_LEFT_LIMIT) begin
                        snake_q = lps_pkg::SNAKE_RIGHT_END;
                        moving_left_q = 1'b0;
                     end
                  end else begin
                     snake_q = snake_q >> 1;
                     if (snake_q < lps_pkg::SNAKE_START) begin
                        snake_q = lps_pkg::SNAKE_TURN_LEFT;
                        moving_left_q = 1'b1;
                     end
                  end
               end else begin
                  down_q = down_q - lps_pkg::LED_W'(1);
               end
               tick_q = '0;
               stepped = 1'b1;
            end
         end
         lps_pkg::OP_PREV, lps_pkg::OP_NEXT: begin
            mode_q = ~mode_q;
            snake_q = lps_pkg::SNAKE_START;
            moving_left_q = 1'b1;
            down_q = lps_pkg::COUNT_START;
            tick_q = '0;
            stepped = 1'b1;
         end
         default: ;
      endcase
      res.led_pattern = mode_q ? down_q : snake_q;
      res.active_mode = mode_q;
      res.stepped = stepped;
      return res;
   endfunction

   function automatic logic [lps_pkg::POT_W-1:0] pick_pot();
      logic [lps_pkg::POT_W-1:0] edges[10];
      edges = '{10'd0, 10'd204, 10'd205, 10'd409, 10'd410,
                10'd614, 10'd615, 10'd819, 10'd820, 10'd1023};
      if ($urandom_range(7) == 0) return edges[$urandom_range(9)];
      return lps_pkg::POT_W'($urandom_range(1023));
   endfunction

   task automatic add_cmd(input logic [lps_pkg::OPCODE_W-1:0] op,
                          input logic [lps_pkg::POT_W-1:0] pot);
      led_cmd_type c;
      c.opcode = op;
      c.pot_sample = pot;
      pending_cmds.push_back(c);
      issued_count++;
   endtask

   task automatic add_random_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 90)      add_cmd(lps_pkg::OP_TICK, pick_pot());
      else if (r < 93) add_cmd(lps_pkg::OP_PREV, pick_pot());
      else if (r < 96) add_cmd(lps_pkg::OP_NEXT, pick_pot());
      else             add_cmd(OP_UNUSED, pick_pot());
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_count != issued_count || expected_leds.size() != 0);
   endtask

   task automatic load_base_delay(input logic [lps_pkg::BASE_W-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      base_delay_q = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input lps_pkg::result_type exp_r,
                                  input lps_pkg::result_type act_r);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("%0t %s: expected led %02h mode %0d stepped %0d, %s %02h mode %0d stepped %0d",
                  $realtime, what, exp_r.led_pattern, exp_r.active_mode, exp_r.stepped,
                  "got led", act_r.led_pattern, act_r.active_mode, act_r.stepped);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      led_cmd_type c;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            c.opcode = req_chan.opcode;
            c.pot_sample = req_chan.pot_sample;
            expected_leds.push_back(step_led_state(c));
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               c = pending_cmds.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.opcode <= c.opcode;
               req_chan.pot_sample <= c.pot_sample;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : check_rsp
      lps_pkg::result_type act_r;
      lps_pkg::result_type exp_r;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            act_r.led_pattern = rsp_chan.led_pattern;
            act_r.active_mode = rsp_chan.active_mode;
            act_r.stepped = rsp_chan.stepped;
            if (expected_leds.size() == 0) begin
               report_mismatch("unexpected beat", '0, act_r);
            end else begin
               exp_r = expected_leds.pop_front();
               if (act_r.led_pattern !== exp_r.led_pattern ||
                   act_r.active_mode !== exp_r.active_mode ||
                   act_r.stepped !== exp_r.stepped)
                  report_mismatch("beat mismatch", exp_r, act_r);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("led_pattern_sequencer: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [lps_pkg::BASE_W-1:0] phase_base[NUM_PHASES];
      req_chan.valid = 1'b0;
      req_chan.opcode = lps_pkg::OP_TICK;
      req_chan.pot_sample = '0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset delay, unused opcode, both presses
      add_cmd(lps_pkg::OP_TICK, 10'd0);
      add_cmd(lps_pkg::OP_TICK, 10'd1023);
      add_cmd(OP_UNUSED, 10'd1023);
      add_cmd(lps_pkg::OP_PREV, 10'd341);
      add_cmd(lps_pkg::OP_TICK, 10'd682);
      add_cmd(lps_pkg::OP_NEXT, 10'd0);
      add_cmd(OP_UNUSED, 10'd0);

      // directed: shortest delay across the tier edges, then snake and counter steps
      load_base_delay(12'd1);
      add_cmd(lps_pkg::OP_TICK, 10'd204);
      add_cmd(lps_pkg::OP_TICK, 10'd205);
      add_cmd(lps_pkg::OP_TICK, 10'd409);
      add_cmd(lps_pkg::OP_TICK, 10'd410);
      add_cmd(lps_pkg::OP_TICK, 10'd614);
      add_cmd(lps_pkg::OP_TICK, 10'd615);
      add_cmd(lps_pkg::OP_TICK, 10'd819);
      add_cmd(lps_pkg::OP_TICK, 10'd820);
      add_cmd(lps_pkg::OP_TICK, 10'd0);
      add_cmd(lps_pkg::OP_TICK, 10'd1023);
      repeat (4) add_cmd(lps_pkg::OP_TICK, 10'd0);
      add_cmd(lps_pkg::OP_PREV, 10'd1023);
      repeat (2) add_cmd(lps_pkg::OP_TICK, 10'd0);

      phase_base[0] = 12'd1;
      phase_base[1] = 12'd0;
      phase_base[2] = 12'd4095;
      phase_base[3] = lps_pkg::BASE_W'($urandom_range(2, 40));
      phase_base[4] = lps_pkg::BASE_W'($urandom_range(1, 4095));
      phase_base[5] = 12'd2;
      phase_base[6] = 12'd8;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         load_base_delay(phase_base[ph]);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
            default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
         endcase
         if (phase_base[ph] == 0) begin
            // every tick steps: long runs take the counter through its wrap
            repeat (260) add_cmd(lps_pkg::OP_TICK, pick_pot());
            add_cmd(lps_pkg::OP_NEXT, pick_pot());
            repeat (260) add_cmd(lps_pkg::OP_TICK, pick_pot());
         end else begin
            repeat (210) add_random_cmd();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_leds.size() == 0)
         $display("led_pattern_sequencer: match");
      else
         $display("led_pattern_sequencer: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
